>>> rtl/mdr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdr_pkg
// Shared types and constants for the multichannel deadband reporter.
// ----------------------------------------------------------------------------
package mdr_pkg;

   // Channel count default and per-channel reset values.
   localparam int unsigned CHANNELS_DEFAULT = 18;
   localparam logic [15:0] DEFAULT_THRESHOLD_MV = 16'd100;
   localparam logic signed [15:0] FORCE_PRELOAD_MV = -16'sd100;
   localparam logic signed [15:0] LAST_RESET_MV = 16'sd0;

   // Operation codes carried in the op field.
   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_SET    = 2'd1,
      OP_FORCE  = 2'd2
   } op_type;

   // Sequencer states.
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   // Input beat.
   typedef struct packed {
      logic [1:0]         op;
      logic [4:0]         channel_id;
      logic signed [15:0] sample_mv;
      logic [15:0]        threshold_mv;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [5:0]         report_channel;
      logic signed [15:0] report_mv;
   } rsp_type;

   // Controls from the sequencer to the datapath.
   typedef struct packed {
      logic req_ready;
      logic exec_fire;
   } ctrl_type;

endpackage

`default_nettype wire

>>> rtl/mdr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdr_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mdr_ram #(
   parameter int unsigned DEPTH  = 18,
   parameter int unsigned WIDTH  = 16,
   parameter int unsigned ADDR_W = 5
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/mdr_fsm.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mdr_fsm
// Two-state sequencer: take a beat and read the tables, then update them.
// ----------------------------------------------------------------------------
module mdr_fsm
   import mdr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   input  wire logic     out_free,
   output ctrl_type      ctrl
);

   state_type state_ff;
   state_type state_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      ctrl = '0;
      unique case (state_ff)
         ST_IDLE: ctrl.req_ready = 1'b1;
         ST_EXEC: ctrl.exec_fire = out_free;
         default: ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/multichannel_deadband_reporter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multichannel_deadband_reporter_unit
// Report-by-exception filter: per channel threshold and last report, kept in
// two small RAMs and updated by a read-modify-write sequence.
// ----------------------------------------------------------------------------
//   Channel   Direction   Beat
//   req_      in          op, channel id, sample, threshold
//   rsp_      out         reported channel id and value
//
// Each beat is handled as a table read in the accept cycle, then a compare and
// write-back cycle. The write-back cycle waits while an earlier
// result still sits in the output register and is not being taken.
// After reset per-entry valid bits make both tables read as their reset
// values at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module multichannel_deadband_reporter_unit
   import mdr_pkg::*;
#(
   parameter int unsigned CHANNELS = CHANNELS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_payload,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_payload
);

   localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [5:0] LAST_CH = 6'(CHANNELS - 1);

   ctrl_type ctrl;
   logic     out_free;
   logic     req_fire;

   // Captured beat and its decoded table index.
   req_type          item_ff;
   logic [IDX_W-1:0] idx_ff;
   logic             in_range_ff;
   logic [IDX_W-1:0] chan_idx;
   logic [IDX_W-1:0] rd_addr;
   logic             chan_ok;

   logic [IDX_W-1:0] scan_ptr_ff;
   logic [IDX_W-1:0] scan_ptr_in;

   logic [CHANNELS-1:0] thr_valid_ff;
   logic [CHANNELS-1:0] last_valid_ff;

   logic [15:0]        thr_rd;
   logic [15:0]        last_rd;
   logic [15:0]        thr_cur;
   logic signed [15:0] last_cur;
   logic signed [16:0] diff;
   logic [16:0]        mag;
   logic               report;

   logic               thr_wr;
   logic               last_wr;
   logic signed [15:0] last_wdata;

   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = ctrl.req_ready;
   assign req_fire  = req_valid && ctrl.req_ready;

   mdr_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .ctrl      (ctrl)
   );

   // Decode the addressed channel; ids are one-based.
   assign chan_ok  = (req_payload.channel_id != 5'd0) &&
                     ({1'b0, req_payload.channel_id} <= 6'(CHANNELS));
   assign chan_idx = IDX_W'(req_payload.channel_id - 5'd1);
   assign rd_addr  = (req_payload.op == OP_SAMPLE) ? scan_ptr_ff : chan_idx;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_ff     <= req_payload;
         idx_ff      <= rd_addr;
         in_range_ff <= chan_ok;
      end
   end

   mdr_ram #(
      .DEPTH  (CHANNELS),
      .WIDTH  (16),
      .ADDR_W (IDX_W)
   ) u_thr_ram (
      .clock   (clock),
      .wr_en   (thr_wr),
      .wr_addr (idx_ff),
      .wr_data (item_ff.threshold_mv),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (thr_rd)
   );

   mdr_ram #(
      .DEPTH  (CHANNELS),
      .WIDTH  (16),
      .ADDR_W (IDX_W)
   ) u_last_ram (
      .clock   (clock),
      .wr_en   (last_wr),
      .wr_addr (idx_ff),
      .wr_data (last_wdata),
      .rd_en   (req_fire),
      .rd_addr (rd_addr),
      .rd_data (last_rd)
   );

   // Entries never written read as their reset values.
   assign thr_cur  = thr_valid_ff[idx_ff] ? thr_rd : DEFAULT_THRESHOLD_MV;
   assign last_cur = last_valid_ff[idx_ff] ? $signed(last_rd) : LAST_RESET_MV;

   // Deadband test: magnitude of the 17-bit difference against the threshold.
   assign diff   = {item_ff.sample_mv[15], item_ff.sample_mv} - {last_cur[15], last_cur};
   assign mag    = diff[16] ? 17'(-diff) : 17'(diff);
   assign report = ({1'b0, thr_cur} < mag);

   // Write-back decisions.
   always_comb begin
      thr_wr     = 1'b0;
      last_wr    = 1'b0;
      last_wdata = item_ff.sample_mv;
      if (ctrl.exec_fire) begin
         case (item_ff.op)
            OP_SAMPLE: last_wr = report;
            OP_SET:    thr_wr  = in_range_ff;
            OP_FORCE: begin
               last_wr    = in_range_ff;
               last_wdata = FORCE_PRELOAD_MV;
            end
            default: begin
               thr_wr  = 1'b0;
               last_wr = 1'b0;
            end
         endcase
      end
   end

   // Scan pointer advances after every sample and wraps at the last channel.
   always_comb begin
      scan_ptr_in = scan_ptr_ff;
      if (ctrl.exec_fire && (item_ff.op == OP_SAMPLE)) begin
         if (6'(scan_ptr_ff) >= LAST_CH) begin
            scan_ptr_in = '0;
         end else begin
            scan_ptr_in = scan_ptr_ff + IDX_W'(1);
         end
      end
   end

   // Control state: pointer and entry valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ptr_ff   <= '0;
         thr_valid_ff  <= '0;
         last_valid_ff <= '0;
      end else begin
         scan_ptr_ff <= scan_ptr_in;
         if (thr_wr) begin
            thr_valid_ff[idx_ff] <= 1'b1;
         end
         if (last_wr) begin
            last_valid_ff[idx_ff] <= 1'b1;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.exec_fire && (item_ff.op == OP_SAMPLE) && report) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.exec_fire && (item_ff.op == OP_SAMPLE) && report) begin
         rsp_ff.report_channel <= 6'(idx_ff) + 6'd1;
         rsp_ff.report_mv      <= item_ff.sample_mv;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
